### design/mvb_pkg.sv
package mvb_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int FIELD_W = 48;
	localparam int WEIGHT_W = 17;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

	typedef enum logic [2:0] {
		REG_CURRENT_WEIGHT  = 3'd0,
		REG_PREVIOUS_WEIGHT = 3'd1,
		REG_BLEND_WEIGHT    = 3'd2,
		REG_BLEND_ENABLE    = 3'd3,
		REG_NORMALS_ENABLE  = 3'd4
	} mvb_reg_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] current_weight;
		logic [WEIGHT_W-1:0] previous_weight;
		logic [WEIGHT_W-1:0] blend_weight;
		logic                blend_enable;
		logic                normals_enable;
	} mvb_cfg_t;

	function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
		return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
	endfunction

endpackage

### design/mvb_vtx_in_if.sv
interface mvb_vtx_in_if import mvb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  pos_key_a;
	logic [FIELD_W-1:0]  pos_key_b;
	logic [FIELD_W-1:0]  old_pos_key_a;
	logic [FIELD_W-1:0]  old_pos_key_b;
	logic [FIELD_W-1:0]  nrm_key_a;
	logic [FIELD_W-1:0]  nrm_key_b;
	logic [FIELD_W-1:0]  old_nrm_key_a;
	logic [FIELD_W-1:0]  old_nrm_key_b;
	logic                last_vertex;

	modport source (
		output valid, pos_key_a, pos_key_b, old_pos_key_a, old_pos_key_b,
		output nrm_key_a, nrm_key_b, old_nrm_key_a, old_nrm_key_b, last_vertex,
		input  ready
	);

	modport sink (
		input  valid, pos_key_a, pos_key_b, old_pos_key_a, old_pos_key_b,
		input  nrm_key_a, nrm_key_b, old_nrm_key_a, old_nrm_key_b, last_vertex,
		output ready
	);
endinterface

### design/mvb_vtx_out_if.sv
interface mvb_vtx_out_if import mvb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  out_position;
	logic [FIELD_W-1:0]  out_normal;
	logic                normal_fallback;
	logic                out_last;

	modport source (
		output valid, out_position, out_normal, normal_fallback, out_last,
		input  ready
	);

	modport sink (
		input  valid, out_position, out_normal, normal_fallback, out_last,
		output ready
	);
endinterface

### design/mvb_regs.sv
module mvb_regs import mvb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output mvb_cfg_t              cfg
);

	logic [WEIGHT_W-1:0] current_weight_q;
	logic [WEIGHT_W-1:0] previous_weight_q;
	logic [WEIGHT_W-1:0] blend_weight_q;
	logic                blend_enable_q;
	logic                normals_enable_q;
	logic                wr_en;
	logic [2:0]          reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_weight_q  <= '0;
			previous_weight_q <= '0;
			blend_weight_q    <= WEIGHT_ONE;
			blend_enable_q    <= 1'b0;
			normals_enable_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CURRENT_WEIGHT:  current_weight_q  <= pwdata[WEIGHT_W-1:0];
				REG_PREVIOUS_WEIGHT: previous_weight_q <= pwdata[WEIGHT_W-1:0];
				REG_BLEND_WEIGHT:    blend_weight_q    <= pwdata[WEIGHT_W-1:0];
				REG_BLEND_ENABLE:    blend_enable_q    <= pwdata[0];
				REG_NORMALS_ENABLE:  normals_enable_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CURRENT_WEIGHT:  prdata = APB_DATA_W'(current_weight_q);
			REG_PREVIOUS_WEIGHT: prdata = APB_DATA_W'(previous_weight_q);
			REG_BLEND_WEIGHT:    prdata = APB_DATA_W'(blend_weight_q);
			REG_BLEND_ENABLE:    prdata = APB_DATA_W'(blend_enable_q);
			REG_NORMALS_ENABLE:  prdata = APB_DATA_W'(normals_enable_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.current_weight  = sat_weight(current_weight_q);
	assign cfg.previous_weight = sat_weight(previous_weight_q);
	assign cfg.blend_weight    = sat_weight(blend_weight_q);
	assign cfg.blend_enable    = blend_enable_q;
	assign cfg.normals_enable  = normals_enable_q;

endmodule

### design/mvb_lerp.sv
module mvb_lerp import mvb_pkg::*; #(
	parameter int W = COMPONENT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [3*W-1:0]      key_a,
	input  logic [3*W-1:0]      key_b,
	input  logic [3*W-1:0]      old_key_a,
	input  logic [3*W-1:0]      old_key_b,
	input  logic [WEIGHT_W-1:0] tc,
	input  logic [WEIGHT_W-1:0] tp,
	input  logic [WEIGHT_W-1:0] tb,
	input  logic                blend,
	output logic [3*W-1:0]      res
);

	localparam int PRW = W + WEIGHT_W + 2;

	// a + floor((d*t + 0.5) / 1.0)
	function automatic logic [W-1:0] fin(input logic [W-1:0] base,
		input logic signed [PRW-1:0] p);
		logic signed [PRW-1:0] r;
		r = p + PRW'(32768);
		return W'(base + r[W+15:16]);
	endfunction

	logic signed [WEIGHT_W:0] tcs, tps, tbs;

	assign tcs = signed'({1'b0, tc});
	assign tps = signed'({1'b0, tp});
	assign tbs = signed'({1'b0, tb});

	for (genvar c = 0; c < 3; c++) begin : g_comp
		logic signed [W-1:0]   a, b, oa, ob;
		logic signed [W:0]     dc, dp, db;
		logic signed [PRW-1:0] pc_s1, pp_s1, pb_s3;
		logic [W-1:0]          a_s1, oa_s1;
		logic signed [W-1:0]   cur_s2, prev_s2, cur_s3, prev_s3;
		logic [W-1:0]          res_s4;

		assign a  = key_a[c*W +: W];
		assign b  = key_b[c*W +: W];
		assign oa = old_key_a[c*W +: W];
		assign ob = old_key_b[c*W +: W];
		assign dc = {b[W-1], b} - {a[W-1], a};
		assign dp = {ob[W-1], ob} - {oa[W-1], oa};
		assign db = {cur_s2[W-1], cur_s2} - {prev_s2[W-1], prev_s2};

		always_ff @(posedge clk) begin
			if (en) begin
				pc_s1   <= dc * tcs;
				pp_s1   <= dp * tps;
				a_s1    <= a;
				oa_s1   <= oa;
				cur_s2  <= fin(a_s1, pc_s1);
				prev_s2 <= fin(oa_s1, pp_s1);
				pb_s3   <= db * tbs;
				cur_s3  <= cur_s2;
				prev_s3 <= prev_s2;
				res_s4  <= blend ? fin(prev_s3, pb_s3) : cur_s3;
			end
		end

		assign res[c*W +: W] = res_s4;
	end

endmodule

### design/mvb_norm.sv
module mvb_norm import mvb_pkg::*; #(
	parameter int W = COMPONENT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [3*W-1:0]     v,
	output logic [3*(W-1)-1:0] q,
	output logic [2:0]         neg,
	output logic               zero
);

	localparam int PW = 4*W + 2;
	localparam int QW = W - 1;
	localparam int LW = 2*W;
	localparam int RW = 4*W - 3;

	logic [2*W-2:0]        sq_s1  [3];
	logic [2:0]            neg_s1;
	logic [LW-1:0]         l_s    [W];
	logic [RW-1:0]         r_s    [W][3];
	logic signed [PW-1:0]  p_s    [W][3];
	logic signed [PW-1:0]  k_s    [W][3];
	logic [QW-1:0]         q_s    [W][3];
	logic [2:0]            neg_s  [W];
	logic                  zero_s [W];
	logic [LW-1:0]         len2;

	for (genvar c = 0; c < 3; c++) begin : g_sq
		logic signed [W-1:0]   vc;
		logic signed [2*W-1:0] prod;
		assign vc   = v[c*W +: W];
		assign prod = vc * vc;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s1[c] <= prod[2*W-2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= {v[3*W-1], v[2*W-1], v[W-1]};
		end
	end

	assign len2 = LW'(sq_s1[0]) + LW'(sq_s1[1]) + LW'(sq_s1[2]);

	// search starts at q = 0, so k = 2q-1 = -1: P = k*k*L, K = k*L
	always_ff @(posedge clk) begin
		if (en) begin
			l_s[0]    <= len2;
			neg_s[0]  <= neg_s1;
			zero_s[0] <= (len2 == '0);
			for (int c = 0; c < 3; c++) begin
				r_s[0][c] <= RW'(sq_s1[c]) << (2*W-2);
				p_s[0][c] <= PW'(len2);
				k_s[0][c] <= -signed'(PW'(len2));
				q_s[0][c] <= '0;
			end
		end
	end

	for (genvar i = 1; i < W; i++) begin : g_iter
		localparam int J = W - 1 - i;
		for (genvar c = 0; c < 3; c++) begin : g_c
			logic signed [PW-1:0] pt, rv;
			logic                 take;
			assign rv   = signed'(PW'(r_s[i-1][c]));
			assign pt   = p_s[i-1][c] + (k_s[i-1][c] <<< (J+2))
				+ signed'(PW'(l_s[i-1]) << (2*J+2));
			assign take = (pt <= rv) && !zero_s[i-1];
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[i][c] <= r_s[i-1][c];
					if (take) begin
						p_s[i][c] <= pt;
						k_s[i][c] <= k_s[i-1][c] + signed'(PW'(l_s[i-1]) << (J+1));
						q_s[i][c] <= q_s[i-1][c] | QW'(1 << J);
					end else begin
						p_s[i][c] <= p_s[i-1][c];
						k_s[i][c] <= k_s[i-1][c];
						q_s[i][c] <= q_s[i-1][c];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				l_s[i]    <= l_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				zero_s[i] <= zero_s[i-1];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_out
		assign q[c*QW +: QW] = q_s[W-1][c];
	end
	assign neg  = neg_s[W-1];
	assign zero = zero_s[W-1];

endmodule

### design/morph_vertex_blend_core.sv
// Morph vertex blend core.
// vtx_in carries one vertex per transfer: current and previous clip keyframe
// positions and normals plus last_vertex. vtx_out returns one result per
// vertex, in order: blended position, unit normal (zero with normals off),
// fallback flag, out_last. Weights and enables are to be written over the APB
// port only while no vertex is in flight; the block does not enforce this.
// pready is tied high, registers read back as written. The pipeline runs
// through keyframe mixing and crossfade (lerp registers s1 to s4), squaring,
// normalizer setup, COMPONENT_WIDTH - 1 stages of the digit-by-digit
// normalizer (one quotient bit per stage) and the output register.
// Throughput is one vertex per cycle unless vtx_out stalls. Valid bits
// travel with the data. When vtx_out.ready is low with a result waiting,
// the whole pipeline holds; nothing is dropped or repeated, and vtx_in.ready
// follows. Reset clears all valid bits and loads the register defaults
// (weights 0, blend weight 1.0, blending and normals off).
module morph_vertex_blend_core import mvb_pkg::*; #(
	parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	mvb_vtx_in_if.sink            vtx_in,
	mvb_vtx_out_if.source         vtx_out
);

	localparam int W   = COMPONENT_WIDTH;
	localparam int QW  = W - 1;
	localparam int LAT = W + 6;
	localparam int NRM = W + 4;
	localparam logic [W-1:0] UNIT = W'(2**(W-2));

	mvb_cfg_t         cfg;
	logic             adv;
	logic [LAT-1:0]   vld_s;
	logic [3*W+47:0]  key_w [8];
	logic [3*W-1:0]   pos_res, nrm_res;
	logic [3*QW-1:0]  nq;
	logic [2:0]       nneg;
	logic             nzero;
	logic [3*W-1:0]   pos_dly_s  [W+1];
	logic             last_dly_s [W+5];
	logic [3*W-1:0]   nrm_vec;
	logic [3*W+47:0]  pos_w, nrm_w;
	logic [FIELD_W-1:0] out_position_q, out_normal_q;
	logic             normal_fallback_q, out_last_q;

	mvb_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	assign adv          = !vld_s[LAT-1] || vtx_out.ready;
	assign vtx_in.ready = adv;

	assign key_w[0] = {(3*W)'(0), vtx_in.pos_key_a};
	assign key_w[1] = {(3*W)'(0), vtx_in.pos_key_b};
	assign key_w[2] = {(3*W)'(0), vtx_in.old_pos_key_a};
	assign key_w[3] = {(3*W)'(0), vtx_in.old_pos_key_b};
	assign key_w[4] = {(3*W)'(0), vtx_in.nrm_key_a};
	assign key_w[5] = {(3*W)'(0), vtx_in.nrm_key_b};
	assign key_w[6] = {(3*W)'(0), vtx_in.old_nrm_key_a};
	assign key_w[7] = {(3*W)'(0), vtx_in.old_nrm_key_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], vtx_in.valid};
		end
	end

	mvb_lerp #(.W(W)) u_pos_lerp (
		.clk, .en(adv),
		.key_a(key_w[0][3*W-1:0]), .key_b(key_w[1][3*W-1:0]),
		.old_key_a(key_w[2][3*W-1:0]), .old_key_b(key_w[3][3*W-1:0]),
		.tc(cfg.current_weight), .tp(cfg.previous_weight), .tb(cfg.blend_weight),
		.blend(cfg.blend_enable), .res(pos_res)
	);

	mvb_lerp #(.W(W)) u_nrm_lerp (
		.clk, .en(adv),
		.key_a(key_w[4][3*W-1:0]), .key_b(key_w[5][3*W-1:0]),
		.old_key_a(key_w[6][3*W-1:0]), .old_key_b(key_w[7][3*W-1:0]),
		.tc(cfg.current_weight), .tp(cfg.previous_weight), .tb(cfg.blend_weight),
		.blend(cfg.blend_enable), .res(nrm_res)
	);

	mvb_norm #(.W(W)) u_norm (
		.clk, .en(adv), .v(nrm_res), .q(nq), .neg(nneg), .zero(nzero)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_dly_s[0]  <= pos_res;
			last_dly_s[0] <= vtx_in.last_vertex;
			for (int i = 1; i < W+1; i++) pos_dly_s[i] <= pos_dly_s[i-1];
			for (int i = 1; i < W+5; i++) last_dly_s[i] <= last_dly_s[i-1];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (!cfg.normals_enable) begin
				nrm_vec[c*W +: W] = '0;
			end else if (nzero) begin
				nrm_vec[c*W +: W] = (c == 1) ? UNIT : '0;
			end else if (nneg[c]) begin
				nrm_vec[c*W +: W] = W'(-W'(nq[c*QW +: QW]));
			end else begin
				nrm_vec[c*W +: W] = W'(nq[c*QW +: QW]);
			end
		end
	end

	assign pos_w = {48'(0), pos_dly_s[W]};
	assign nrm_w = {48'(0), nrm_vec};

	always_ff @(posedge clk) begin
		if (adv) begin
			out_position_q    <= pos_w[FIELD_W-1:0];
			out_normal_q      <= nrm_w[FIELD_W-1:0];
			normal_fallback_q <= cfg.normals_enable && nzero;
			out_last_q        <= last_dly_s[W+4];
		end
	end

	assign vtx_out.valid           = vld_s[LAT-1];
	assign vtx_out.out_position    = out_position_q;
	assign vtx_out.out_normal      = out_normal_q;
	assign vtx_out.normal_fallback = normal_fallback_q;
	assign vtx_out.out_last        = out_last_q;

`ifndef ASSERT_OFF
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NRM] |-> (nq[QW-1:0] <= UNIT) && (nq[2*QW-1:QW] <= UNIT)
			&& (nq[3*QW-1:2*QW] <= UNIT))
		else $error("normalizer quotient above unit");

	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NRM] && nzero |-> nq == '0)
		else $error("zero-length normal gave nonzero quotient");

	a_fallback_word: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_out.valid && vtx_out.normal_fallback |->
			vtx_out.out_normal == FIELD_W'({48'(0), W'(0), UNIT, W'(0)}))
		else $error("fallback normal is not (0,1,0)");
`endif

endmodule
